FILE: hw/rtl/obl_pkg.sv
// Package for the order book level table: field widths, status codes and
// parameter defaults. No dependencies.
`timescale 1ns / 1ps

package obl_pkg;

    localparam int unsigned NUM_PRODUCTS_DEF    = 8;
    localparam int unsigned LEVELS_PER_SIDE_DEF = 64;

    localparam int unsigned OP_W     = 1;
    localparam int unsigned PROD_W   = 3;
    localparam int unsigned PRICE_W  = 32;
    localparam int unsigned VOL_W    = 48;
    localparam int unsigned STATUS_W = 3;

    localparam logic [VOL_W-1:0] VOL_MAX = {VOL_W{1'b1}};

    localparam logic [OP_W-1:0] OP_UPDATE   = 1'b0;
    localparam logic [OP_W-1:0] OP_SNAPSHOT = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_CHANGED  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_REMOVED  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_ABSENT   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_DROPPED  = 3'd4;

endpackage

FILE: hw/rtl/order_book_level_table_unit.sv
// Order book price-level table: scan, update and write-back of one level change.
// Depends on obl_pkg.
`timescale 1ns / 1ps

// How to use this block:
// An item (operation, product, side, price, volume) is taken at a rising edge
// with start high and busy low. The block then holds busy high, scans the
// selected table in its level memory one slot per cycle, and writes back the
// changed entry. The result (status, level volume) is on the o_ result ports
// for one cycle with o_done high, after the scan and update states; busy drops
// in that same cycle, so the next item can be taken at the edge that ends it.
// The block takes no new item until it is through with the last one.
// The scan rate is set by the single read port of the level memory, which
// delivers one stored level per cycle to the match and free-slot search.
// An item whose product index is NUM_PRODUCTS or more is answered with
// "dropped" in the next cycle without a scan, and busy never rises for it.
// The receiver cannot stall: every result must be taken in its strobe cycle.
// After reset the block clears the valid marks of the whole memory, one entry
// a cycle, with busy high; no item is accepted during this clearing pass.
module order_book_level_table_unit #(
    parameter int unsigned NUM_PRODUCTS    = obl_pkg::NUM_PRODUCTS_DEF,
    parameter int unsigned LEVELS_PER_SIDE = obl_pkg::LEVELS_PER_SIDE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [obl_pkg::OP_W-1:0]      i_operation,
    input  logic [obl_pkg::PROD_W-1:0]    i_product,
    input  logic                          i_side,
    input  logic [obl_pkg::PRICE_W-1:0]   i_price,
    input  logic [obl_pkg::VOL_W-1:0]     i_volume,
    output logic                          o_done,
    output logic [obl_pkg::STATUS_W-1:0]  o_status,
    output logic [obl_pkg::VOL_W-1:0]     o_level_volume
);
    import obl_pkg::*;

    localparam int unsigned DEPTH  = NUM_PRODUCTS * 2 * LEVELS_PER_SIDE;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W  = $clog2(LEVELS_PER_SIDE + 1);
    localparam int unsigned WORD_W = 1 + PRICE_W + VOL_W;

    localparam logic [CNT_W-1:0]  LEVELS_CNT = CNT_W'(LEVELS_PER_SIDE);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(DEPTH - 1);

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_SCAN   = 4'b0100,
        S_UPDATE = 4'b1000
    } t_state;

    t_state r_state;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] r_rd_data;
    logic [ADDR_W-1:0] w_rd_addr;
    logic              w_we;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [WORD_W-1:0] w_wr_data;

    logic [ADDR_W-1:0] r_clr_addr;
    logic [CNT_W-1:0]  r_slot;
    logic              r_pend;
    logic [ADDR_W-1:0] r_pend_addr;
    logic [ADDR_W-1:0] r_base;

    logic [OP_W-1:0]    r_op;
    logic [PRICE_W-1:0] r_price;
    logic [VOL_W-1:0]   r_vol;

    logic              r_found;
    logic [ADDR_W-1:0] r_hit_addr;
    logic [VOL_W-1:0]  r_hit_amt;
    logic              r_have_free;
    logic [ADDR_W-1:0] r_free_addr;

    logic                r_done;
    logic [STATUS_W-1:0] r_status;
    logic [VOL_W-1:0]    r_level_volume;

    logic                w_accept;
    logic                w_prod_ok;
    logic [ADDR_W-1:0]   w_base;
    logic                w_rd_valid;
    logic [PRICE_W-1:0]  w_rd_price;
    logic [VOL_W-1:0]    w_rd_amt;
    logic [VOL_W:0]      w_sum;
    logic [VOL_W-1:0]    w_sat;
    logic [STATUS_W-1:0] w_status;
    logic [VOL_W-1:0]    w_result_vol;

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_level_volume = r_level_volume;

    assign w_accept  = start && !busy;
    assign w_prod_ok = (32'(i_product) < NUM_PRODUCTS);
    assign w_base    = ADDR_W'(32'({i_product, i_side}) * LEVELS_PER_SIDE);

    assign w_rd_valid = r_rd_data[WORD_W-1];
    assign w_rd_price = r_rd_data[VOL_W +: PRICE_W];
    assign w_rd_amt   = r_rd_data[VOL_W-1:0];

    assign w_rd_addr = r_base + ADDR_W'(r_slot);

    assign w_sum = {1'b0, r_hit_amt} + {1'b0, r_vol};
    assign w_sat = w_sum[VOL_W] ? VOL_MAX : w_sum[VOL_W-1:0];

    // Clearing writes; the item's decision once the scan has seen every slot.
    always_comb begin
        w_we         = 1'b0;
        w_wr_addr    = r_clr_addr;
        w_wr_data    = '0;
        w_status     = STAT_DROPPED;
        w_result_vol = '0;
        if (r_state == S_CLEAR) begin
            w_we = 1'b1;
        end else if (r_state == S_UPDATE) begin
            priority if (r_op == OP_UPDATE && r_vol == '0) begin
                w_we      = r_found;
                w_wr_addr = r_hit_addr;
                w_status  = r_found ? STAT_REMOVED : STAT_ABSENT;
            end else if (r_found) begin
                w_we         = 1'b1;
                w_wr_addr    = r_hit_addr;
                w_result_vol = (r_op == OP_UPDATE) ? w_sat : r_vol;
                w_wr_data    = {1'b1, r_price, w_result_vol};
                w_status     = STAT_CHANGED;
            end else if (r_have_free) begin
                w_we         = 1'b1;
                w_wr_addr    = r_free_addr;
                w_result_vol = r_vol;
                w_wr_data    = {1'b1, r_price, r_vol};
                w_status     = STAT_INSERTED;
            end else begin
                w_status = STAT_DROPPED;
            end
        end
    end

    // Level memory: one write port, one registered read port. Read data is used
    // only in the scan and writes happen only in the clear and update states, so
    // a read that is used never meets a write to the same entry.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_slot     <= '0;
            r_pend     <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_prod_ok) begin
                            r_state <= S_SCAN;
                            r_slot  <= '0;
                            r_pend  <= 1'b0;
                        end else begin
                            r_done <= 1'b1;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_slot < LEVELS_CNT) begin
                        r_slot <= r_slot + CNT_W'(1);
                        r_pend <= 1'b1;
                    end else begin
                        r_pend  <= 1'b0;
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

    // Transaction payload, scan results and result registers; no reset needed.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_accept) begin
            r_op        <= i_operation;
            r_price     <= i_price;
            r_vol       <= i_volume;
            r_base      <= w_base;
            r_found     <= 1'b0;
            r_have_free <= 1'b0;
            r_status       <= STAT_DROPPED;
            r_level_volume <= '0;
        end
        if (r_state == S_SCAN) begin
            r_pend_addr <= w_rd_addr;
            if (r_pend) begin
                if (w_rd_valid) begin
                    if (!r_found && w_rd_price == r_price) begin
                        r_found    <= 1'b1;
                        r_hit_addr <= r_pend_addr;
                        r_hit_amt  <= w_rd_amt;
                    end
                end else if (!r_have_free) begin
                    r_have_free <= 1'b1;
                    r_free_addr <= r_pend_addr;
                end
            end
        end
        if (r_state == S_UPDATE) begin
            r_status       <= w_status;
            r_level_volume <= w_result_vol;
        end
    end

`ifndef NO_ASSERTIONS
    a_write_only_clear_or_update : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_CLEAR || r_state == S_UPDATE))
        else $error("level memory written outside clear or update");

    a_zero_volume_when_absent : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == STAT_REMOVED || o_status == STAT_ABSENT ||
                    o_status == STAT_DROPPED)) |-> (o_level_volume == '0))
        else $error("nonzero level volume for an absent level");

    a_done_has_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state == S_UPDATE) || $past(w_accept && !w_prod_ok)))
        else $error("result strobe without a finished transaction");

    a_scan_reaches_update : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_slot == LEVELS_CNT) |=> (r_state == S_UPDATE))
        else $error("scan did not end in the update state");
`endif

endmodule

FILE: dv/order_book_level_table_unit_tb.sv
// Self-checking testbench for order_book_level_table_unit: directed rows, then random level
// changes checked against a behavioral price-level table. Depends on obl_pkg and the unit.
`timescale 1ns / 1ps

module order_book_level_table_unit_tb;

    import obl_pkg::*;

    localparam int NUM_PROD   = NUM_PRODUCTS_DEF;
    localparam int LEVELS     = LEVELS_PER_SIDE_DEF;
    localparam int DEPTH      = NUM_PROD * 2 * LEVELS;
    localparam int NUM_ROWS   = 21;
    localparam int NUM_RANDOM = 350;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VOL_W-1:0]    level_volume;
    } t_level_result;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [PROD_W-1:0]   prod;
        logic                side;
        logic [PRICE_W-1:0]  px;
        logic [VOL_W-1:0]    vol;
        logic                typed;
        logic [STATUS_W-1:0] status;
        logic [VOL_W-1:0]    lv;
    } t_level_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [OP_W-1:0]      i_operation = OP_UPDATE;
    logic [PROD_W-1:0]    i_product = '0;
    logic                 i_side = 1'b0;
    logic [PRICE_W-1:0]   i_price = '0;
    logic [VOL_W-1:0]     i_volume = '0;
    logic                 o_done;
    logic [STATUS_W-1:0]  o_status;
    logic [VOL_W-1:0]     o_level_volume;

    // Typed expectation that travels with a directed row.
    logic                 row_typed = 1'b0;
    logic [STATUS_W-1:0]  row_status = '0;
    logic [VOL_W-1:0]     row_lv = '0;

    // Behavioral copy of the level memory.
    bit                   book_valid [DEPTH];
    logic [PRICE_W-1:0]   book_price [DEPTH];
    logic [VOL_W-1:0]     book_amount [DEPTH];

    t_level_result        expected_levels [$];
    t_level_row           directed_rows [NUM_ROWS];
    logic [PRICE_W-1:0]   price_pool [12];
    int                   mismatch_count = 0;
    int                   burst_left = 0;

    order_book_level_table_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_product      (i_product),
        .i_side         (i_side),
        .i_price        (i_price),
        .i_volume       (i_volume),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_level_volume (o_level_volume)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Applies one level change to the behavioral book and returns its result.
    function automatic void apply_level_change(input logic [OP_W-1:0] op,
                                               input logic [PROD_W-1:0] prod,
                                               input logic side,
                                               input logic [PRICE_W-1:0] px,
                                               input logic [VOL_W-1:0] vol,
                                               output logic [STATUS_W-1:0] st,
                                               output logic [VOL_W-1:0] lv);
        int base;
        int hit;
        int free_slot;
        bit found;
        bit have_free;
        logic [VOL_W:0] sum;
        st = STAT_DROPPED;
        lv = '0;
        found = 1'b0;
        have_free = 1'b0;
        hit = 0;
        free_slot = 0;
        if (int'(prod) >= NUM_PROD) begin
            return;
        end
        base = (int'(prod) * 2 + int'(side)) * LEVELS;
        for (int k = 0; k < LEVELS; k++) begin
            if (book_valid[base + k]) begin
                if (!found && book_price[base + k] == px) begin
                    found = 1'b1;
                    hit = base + k;
                end
            end else if (!have_free) begin
                have_free = 1'b1;
                free_slot = base + k;
            end
        end
        if (op == OP_UPDATE && vol == '0) begin
            if (found) begin
                book_valid[hit] = 1'b0;
                st = STAT_REMOVED;
            end else begin
                st = STAT_ABSENT;
            end
        end else if (found) begin
            if (op == OP_UPDATE) begin
                sum = {1'b0, book_amount[hit]} + {1'b0, vol};
                book_amount[hit] = sum[VOL_W] ? VOL_MAX : sum[VOL_W-1:0];
            end else begin
                book_amount[hit] = vol;
            end
            st = STAT_CHANGED;
            lv = book_amount[hit];
        end else if (have_free) begin
            book_valid[free_slot] = 1'b1;
            book_price[free_slot] = px;
            book_amount[free_slot] = vol;
            st = STAT_INSERTED;
            lv = vol;
        end
    endfunction

    // Checks each result strobe first, then records the transaction accepted at this edge.
    always @(posedge i_clk) begin : level_monitor
        t_level_result want;
        logic [STATUS_W-1:0] st;
        logic [VOL_W-1:0] lv;
        if (i_rst_n && o_done === 1'b1) begin
            if (expected_levels.size() == 0) begin
                $error("unexpected result: status %0d level_volume %0h", o_status,
                       o_level_volume);
                mismatch_count++;
            end else begin
                want = expected_levels.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    mismatch_count++;
                end
                if (o_level_volume !== want.level_volume) begin
                    $error("level_volume: expected %0h, actual %0h", want.level_volume,
                           o_level_volume);
                    mismatch_count++;
                end
            end
        end
        if (i_rst_n && start && busy === 1'b0) begin
            apply_level_change(i_operation, i_product, i_side, i_price, i_volume, st, lv);
            if (row_typed) begin
                want.status = row_status;
                want.level_volume = row_lv;
            end else begin
                want.status = st;
                want.level_volume = lv;
            end
            expected_levels = {expected_levels, want};
        end
    end

    function automatic logic [VOL_W-1:0] pick_volume();
        logic [63:0] r;
        r = {$urandom, $urandom};
        unique case ($urandom_range(0, 9))
            0, 1:    return '0;
            2:       return VOL_MAX;
            3:       return VOL_MAX - VOL_W'($urandom_range(0, 255));
            4, 5:    return VOL_W'($urandom_range(1, 1000));
            default: return r[VOL_W-1:0];
        endcase
    endfunction

    function automatic logic [PRICE_W-1:0] pick_price();
        if ($urandom_range(0, 9) < 7) begin
            return price_pool[$urandom_range(0, 11)];
        end
        return $urandom;
    endfunction

    // Drives one transaction and returns at the edge that accepts it. The sender works in
    // bursts; between bursts start may be dropped for a random number of cycles.
    task automatic send_level_change(input logic [OP_W-1:0] op, input logic [PROD_W-1:0] prod,
                                     input logic side, input logic [PRICE_W-1:0] px,
                                     input logic [VOL_W-1:0] vol, input logic typed,
                                     input logic [STATUS_W-1:0] st,
                                     input logic [VOL_W-1:0] lv);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 90) : $urandom_range(0, 4);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 8);
        end
        burst_left--;
        start       <= 1'b1;
        i_operation <= op;
        i_product   <= prod;
        i_side      <= side;
        i_price     <= px;
        i_volume    <= vol;
        row_typed   <= typed;
        row_status  <= st;
        row_lv      <= lv;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (expected_levels.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random_change(input logic [PROD_W-1:0] prod, input logic side,
                                      input logic [PRICE_W-1:0] px,
                                      input logic [VOL_W-1:0] vol);
        logic [OP_W-1:0] op;
        op = ($urandom_range(0, 9) < 7) ? OP_UPDATE : OP_SNAPSHOT;
        send_level_change(op, prod, side, px, vol, 1'b0, STAT_INSERTED, '0);
    endtask

    // Fills one side of one product past capacity, frees a few slots and refills them.
    task automatic fill_side();
        logic [PROD_W-1:0] prod;
        logic side;
        logic [PRICE_W-1:0] base_px;
        logic [VOL_W-1:0] vol;
        prod = PROD_W'($urandom_range(0, NUM_PROD - 1));
        side = 1'($urandom);
        base_px = $urandom;
        for (int k = 0; k < LEVELS + 4; k++) begin
            vol = pick_volume();
            if (vol == '0) vol = 48'd1;
            send_random_change(prod, side, base_px + PRICE_W'(k), vol);
        end
        send_level_change(OP_UPDATE, prod, side, base_px - 32'd1, '0, 1'b0, STAT_ABSENT, '0);
        for (int k = 0; k < 3; k++) begin
            send_level_change(OP_UPDATE, prod, side,
                              base_px + PRICE_W'($urandom_range(0, LEVELS - 1)), '0,
                              1'b0, STAT_ABSENT, '0);
        end
        for (int k = 0; k < 5; k++) begin
            send_random_change(prod, side, $urandom, pick_volume() | 48'd1);
        end
    endtask

    initial begin
        directed_rows = '{
            '{OP_UPDATE,   3'd0, 1'b0, 32'd100,      48'd0,     1'b1, STAT_ABSENT,   48'd0},
            '{OP_UPDATE,   3'd0, 1'b0, 32'd0,        48'd1,     1'b1, STAT_INSERTED, 48'd1},
            '{OP_UPDATE,   3'd0, 1'b0, 32'd0,        VOL_MAX,   1'b1, STAT_CHANGED,  VOL_MAX},
            '{OP_SNAPSHOT, 3'd0, 1'b0, 32'd0,        48'd0,     1'b1, STAT_CHANGED,  48'd0},
            '{OP_UPDATE,   3'd0, 1'b0, 32'd0,        48'd0,     1'b1, STAT_REMOVED,  48'd0},
            '{OP_UPDATE,   3'd0, 1'b0, 32'd0,        48'd0,     1'b1, STAT_ABSENT,   48'd0},
            '{OP_SNAPSHOT, 3'd7, 1'b1, 32'hFFFFFFFF, 48'd0,     1'b1, STAT_INSERTED, 48'd0},
            '{OP_UPDATE,   3'd7, 1'b1, 32'hFFFFFFFF, VOL_MAX,   1'b1, STAT_CHANGED,  VOL_MAX},
            '{OP_UPDATE,   3'd7, 1'b1, 32'hFFFFFFFF, 48'd5,     1'b1, STAT_CHANGED,  VOL_MAX},
            '{OP_SNAPSHOT, 3'd7, 1'b1, 32'hFFFFFFFF, 48'h123,   1'b1, STAT_CHANGED,  48'h123},
            '{OP_UPDATE,   3'd7, 1'b0, 32'hFFFFFFFF, 48'd0,     1'b1, STAT_ABSENT,   48'd0},
            '{OP_UPDATE,   3'd3, 1'b1, 32'hAAAA5555, 48'h5555AAAA5555, 1'b1, STAT_INSERTED,
              48'h5555AAAA5555},
            '{OP_UPDATE,   3'd3, 1'b1, 32'h5555AAAA, 48'hAAAA5555AAAA, 1'b1, STAT_INSERTED,
              48'hAAAA5555AAAA},
            '{OP_UPDATE,   3'd3, 1'b1, 32'hAAAA5555, 48'hAAAA5555AAAA, 1'b1, STAT_CHANGED,
              VOL_MAX},
            '{OP_SNAPSHOT, 3'd3, 1'b1, 32'd1,        48'd7,     1'b0, STAT_INSERTED, 48'd0},
            '{OP_UPDATE,   3'd3, 1'b1, 32'h5555AAAA, 48'd0,     1'b1, STAT_REMOVED,  48'd0},
            '{OP_UPDATE,   3'd3, 1'b1, 32'h1234,     48'd9,     1'b0, STAT_INSERTED, 48'd0},
            '{OP_SNAPSHOT, 3'd3, 1'b1, 32'h5555AAAA, 48'd0,     1'b1, STAT_INSERTED, 48'd0},
            '{OP_UPDATE,   3'd0, 1'b0, 32'd0,        VOL_MAX,   1'b1, STAT_INSERTED, VOL_MAX},
            '{OP_UPDATE,   3'd0, 1'b0, 32'd0,        VOL_MAX,   1'b1, STAT_CHANGED,  VOL_MAX},
            '{OP_UPDATE,   3'd0, 1'b1, 32'd0,        48'd1,     1'b0, STAT_INSERTED, 48'd0}
        };
        price_pool[0] = 32'd0;
        price_pool[1] = 32'hFFFFFFFF;
        price_pool[2] = 32'd1;
        price_pool[3] = 32'h80000000;
        for (int k = 4; k < 12; k++) price_pool[k] = $urandom;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            send_level_change(directed_rows[r].op, directed_rows[r].prod,
                              directed_rows[r].side, directed_rows[r].px,
                              directed_rows[r].vol, directed_rows[r].typed,
                              directed_rows[r].status, directed_rows[r].lv);
        end

        // Random part: most traffic goes to two products so that levels collide often.
        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i == 100 || i == 250) fill_side();
            if (i == 180) wait_for_results();
            send_random_change(($urandom_range(0, 1) == 0) ? PROD_W'($urandom_range(0, 1))
                                                          : PROD_W'($urandom),
                               1'($urandom), pick_price(), pick_volume());
        end

        wait_for_results();
        repeat (LEVELS + 8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_levels.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("Verification failed");
        $finish;
    end

endmodule
